// ===== rtl/core/keyed_table_insert_delete_lookup_top_macros.svh =====
// assertion helpers used by the table logic
`ifndef KEYED_TABLE_INSERT_DELETE_LOOKUP_TOP_MACROS_SVH
`define KEYED_TABLE_INSERT_DELETE_LOOKUP_TOP_MACROS_SVH

// condition must hold on every clock edge out of reset
`define KT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("keyed table invariant violated");

// consequent must hold in the same cycle
`define KT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("keyed table implication violated");

// consequent must hold in the next cycle
`define KT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keyed table sequence violated");

`endif

// ===== rtl/core/ktidl_pkg.sv =====
package ktidl_pkg;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_SPARE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_DUP    = 2'd1,
		ST_ABSENT = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_LOOKUP,
		KIND_INSERT,
		KIND_DELETE
	} kind_t;

	typedef struct packed {
		op_t         op;
		logic [63:0] key;
		logic [31:0] item_value;
	} in_word_t;

	typedef struct packed {
		logic        found;
		logic [31:0] found_value;
		logic [4:0]  entry_index;
		status_t     status;
		logic [4:0]  entries_used;
		logic        is_empty;
		logic        is_full;
	} out_word_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] key;
		logic [31:0] value;
	} cmd_t;

endpackage

// ===== rtl/core/ktidl_front.sv =====
module ktidl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  ktidl_pkg::in_word_t item,
	output logic                cmd_valid,
	output ktidl_pkg::cmd_t     cmd,
	input  logic                cmd_take
);

	ktidl_pkg::cmd_t slot_q [2];
	ktidl_pkg::cmd_t classed;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            do_push;
	logic            do_pop;

	// decode the operation into the work the back end must do
	always_comb begin
		classed.key   = item.key;
		classed.value = item.item_value;
		unique case (item.op)
			ktidl_pkg::OP_INSERT: classed.kind = ktidl_pkg::KIND_INSERT;
			ktidl_pkg::OP_DELETE: classed.kind = ktidl_pkg::KIND_DELETE;
			default:              classed.kind = ktidl_pkg::KIND_LOOKUP;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= classed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ===== rtl/core/ktidl_outq.sv =====
module ktidl_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_push,
	input  ktidl_pkg::out_word_t res_in,
	output logic                 room,
	output logic                 empty,
	input  logic                 pop,
	output ktidl_pkg::out_word_t result
);

	ktidl_pkg::out_word_t slot_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign room    = (cnt_q != 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign result  = slot_q[rd_ptr_q];
	assign do_push = res_push && room;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ===== rtl/core/ktidl_back.sv =====
`include "keyed_table_insert_delete_lookup_top_macros.svh"

module ktidl_back #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  ktidl_pkg::cmd_t      cmd,
	output logic                 cmd_take,
	input  logic                 room,
	output logic                 res_push,
	output ktidl_pkg::out_word_t res_out
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	logic [KEY_BITS-1:0]   key_q [ENTRIES];
	logic [VALUE_BITS-1:0] val_q [ENTRIES];
	logic [CW-1:0]         count_q;
	logic                  busy_q;

	ktidl_pkg::kind_t      kind_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] val_s1;
	logic [ENTRIES-1:0]    match_s1;

	logic [63:0]           val_in;
	logic [ENTRIES-1:0]    match;
	logic                  hit;
	logic [IW-1:0]         idx;
	logic                  tbl_full;
	logic                  do_insert;
	logic                  do_delete;
	logic [CW-1:0]         next_count;
	logic [CW-1:0]         pos;
	logic [15:0]           pos_wide;
	logic [15:0]           used_wide;
	logic [63:0]           hit_val;

	assign cmd_take = cmd_valid && !busy_q && room;
	assign val_in   = {32'b0, cmd.value};

	// compare against every live entry
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = (CW'(i) < count_q) && (key_q[i] == cmd.key[KEY_BITS-1:0]);
		end
	end

	// lowest matching position wins
	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				hit = 1'b1;
				idx = IW'(i);
			end
		end
	end

	assign tbl_full  = (count_q == CW'(ENTRIES));
	assign do_insert = busy_q && (kind_s1 == ktidl_pkg::KIND_INSERT) && !hit && !tbl_full;
	assign do_delete = busy_q && (kind_s1 == ktidl_pkg::KIND_DELETE) && hit;

	always_comb begin
		next_count = count_q;
		if (do_insert) begin
			next_count = count_q + CW'(1);
		end else if (do_delete) begin
			next_count = count_q - CW'(1);
		end
	end

	assign pos       = hit ? CW'(idx) : count_q;
	assign pos_wide  = 16'(pos);
	assign used_wide = 16'(next_count);
	assign hit_val   = 64'(val_q[idx]);
	assign res_push  = busy_q;

	always_comb begin
		res_out.found        = hit;
		res_out.found_value  = '0;
		res_out.entry_index  = pos_wide[4:0];
		res_out.entries_used = used_wide[4:0];
		res_out.is_empty     = (next_count == '0);
		res_out.is_full      = (next_count == CW'(ENTRIES));
		res_out.status       = ktidl_pkg::ST_DONE;
		case (kind_s1)
			ktidl_pkg::KIND_INSERT: begin
				if (hit) begin
					res_out.status = ktidl_pkg::ST_DUP;
				end else if (tbl_full) begin
					res_out.status = ktidl_pkg::ST_FULL;
				end
			end
			ktidl_pkg::KIND_DELETE: begin
				if (!hit) begin
					res_out.status = ktidl_pkg::ST_ABSENT;
				end
			end
			default: begin
				if (hit) begin
					res_out.found_value = hit_val[31:0];
				end else begin
					res_out.status = ktidl_pkg::ST_ABSENT;
				end
			end
		endcase
	end

	// table contents and the held command
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			kind_s1  <= cmd.kind;
			key_s1   <= cmd.key[KEY_BITS-1:0];
			val_s1   <= val_in[VALUE_BITS-1:0];
			match_s1 <= match;
		end
		if (do_delete) begin
			for (int i = 0; i < ENTRIES - 1; i++) begin
				if (IW'(i) >= idx) begin
					key_q[i] <= key_q[i+1];
					val_q[i] <= val_q[i+1];
				end
			end
		end
		if (do_insert) begin
			key_q[count_q[IW-1:0]] <= key_s1;
			val_q[count_q[IW-1:0]] <= val_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
		end else begin
			count_q <= next_count;
			busy_q  <= cmd_take;
		end
	end

	`KT_ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q <= CW'(ENTRIES))
	`KT_ASSERT_NEXT(a_two_phase, clk, arst_n, busy_q, !busy_q)
	`KT_ASSERT_NEXT(a_insert_grows, clk, arst_n, do_insert, count_q == $past(count_q) + CW'(1))
	`KT_ASSERT_NEXT(a_delete_shrinks, clk, arst_n, do_delete, count_q == $past(count_q) - CW'(1))

endmodule

// ===== rtl/core/keyed_table_insert_delete_lookup_top.sv =====
// keyed table: up to ENTRIES key/value pairs kept packed in insertion order
// input side is a queue: drive item and raise push; the word is taken on a
// rising edge with push high and full low. op selects lookup, insert or delete
// (the spare code acts as a lookup)
// result side is a queue: while empty is low the oldest result sits on result;
// raising pop takes it on the next rising edge
// every item gives exactly one result, in order
// a pushed word passes through the input queue, the held command registers and
// the result queue before it shows on result; the table takes no new item
// until it is through with the last, set by the compare-then-update loop on
// the table (a parallel key compare, then the insert or the compacting shift)
// two words queue before the table and two results after it, so either side
// can stall briefly; with pop held low the result queue fills, the table stops
// and full rises once the input queue is full too
// reset empties both queues and clears the entry count; stored keys and values
// need no clearing
module keyed_table_insert_delete_lookup_top #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  ktidl_pkg::in_word_t  item,
	output logic                 empty,
	input  logic                 pop,
	output ktidl_pkg::out_word_t result
);

	ktidl_pkg::cmd_t      cmd;
	logic                 cmd_valid;
	logic                 cmd_take;
	logic                 room;
	logic                 res_push;
	ktidl_pkg::out_word_t res_word;

	ktidl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	ktidl_back #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.room      (room),
		.res_push  (res_push),
		.res_out   (res_word)
	);

	ktidl_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_word),
		.room     (room),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
